FILE: rtl/core/stjl_pkg.sv
// Shared types, constants and curve coefficient tables for the speed to
// joystick level unit. No dependencies.
package stjl_pkg;

	localparam int SPD_W  = 16;             // speed operand width
	localparam int LVL_W  = 12;             // joystick code width
	localparam int A_W    = 36;             // Horner accumulator width (Q16)
	localparam int FIX_SH = 16;             // fraction bits of the accumulator
	localparam int CNT_W  = $clog2(SPD_W);  // bit counter of the serial multiplier

	// operation codes of a command item
	typedef enum logic [1:0] {
		OP_GEAR1  = 2'd0,
		OP_GEAR2  = 2'd1,
		OP_DIRECT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// polynomial curves
	typedef enum logic [1:0] {
		CRV_G1_FWD  = 2'd0,
		CRV_G1_TURN = 2'd1,
		CRV_G2_FWD  = 2'd2,
		CRV_G2_TURN = 2'd3
	} crv_t;

	// top level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_PEND
	} ctl_state_t;

	// Horner unit sequencer
	typedef enum logic [1:0] {
		HN_IDLE,
		HN_MUL,
		HN_ADD,
		HN_CLAMP
	} hn_state_t;

	// fixed codes for threshold overrides and zero speed
	localparam logic [LVL_W-1:0] G1F_HI_CODE   = 12'd2800;
	localparam logic [LVL_W-1:0] G1F_LO_CODE   = 12'd850;
	localparam logic [LVL_W-1:0] G1F_ZERO_CODE = 12'd2028;
	localparam logic [LVL_W-1:0] G1T_LO_CODE   = 12'd2800;
	localparam logic [LVL_W-1:0] G1T_ZERO_CODE = 12'd2044;
	localparam logic [LVL_W-1:0] G2F_HI_CODE   = 12'd3170;
	localparam logic [LVL_W-1:0] G2F_LO_CODE   = 12'd1020;
	localparam logic [LVL_W-1:0] G2F_ZERO_CODE = 12'd2040;
	localparam logic [LVL_W-1:0] G2T_LO_CODE   = 12'd3129;
	localparam logic [LVL_W-1:0] G2T_HI_CODE   = 12'd780;
	localparam logic [LVL_W-1:0] G2T_ZERO_CODE = 12'd2000;

	// request to a Horner lane
	typedef struct packed {
		logic                    start;
		crv_t                    curve;
		logic signed [SPD_W-1:0] speed;
	} hn_req_t;

	// response of a Horner lane
	typedef struct packed {
		logic             done;
		logic [LVL_W-1:0] level;
	} hn_rsp_t;

	// Q16 cubic coefficients, highest power first
	function automatic logic signed [A_W-1:0] crv_coef(crv_t crv, logic [1:0] idx);
		logic signed [A_W-1:0] c;
		c = '0;
		case (crv)
			CRV_G1_FWD: begin
				case (idx)
					2'd0:    c = -36'sd931725312;
					2'd1:    c = -36'sd122912768;
					2'd2:    c = 36'sd370422579;
					default: c = 36'sd127710003;
				endcase
			end
			CRV_G1_TURN: begin
				case (idx)
					2'd0:    c = 36'sd12021924;
					2'd1:    c = -36'sd1255539;
					2'd2:    c = -36'sd75202560;
					default: c = 36'sd132356506;
				endcase
			end
			CRV_G2_FWD: begin
				case (idx)
					2'd0:    c = 36'sd1291059;
					2'd1:    c = -36'sd27996979;
					2'd2:    c = 36'sd104674099;
					default: c = 36'sd130659123;
				endcase
			end
			default: begin
				case (idx)
					2'd0:    c = 36'sd34360525;
					2'd1:    c = -36'sd10702029;
					2'd2:    c = -36'sd121818317;
					default: c = 36'sd125665280;
				endcase
			end
		endcase
		return c;
	endfunction

	// lower clamp limit of a curve
	function automatic logic [LVL_W-1:0] crv_lo(crv_t crv);
		logic [LVL_W-1:0] v;
		case (crv)
			CRV_G1_FWD:  v = 12'd850;
			CRV_G1_TURN: v = 12'd850;
			CRV_G2_FWD:  v = 12'd1020;
			default:     v = 12'd780;
		endcase
		return v;
	endfunction

	// upper clamp limit of a curve
	function automatic logic [LVL_W-1:0] crv_hi(crv_t crv);
		logic [LVL_W-1:0] v;
		case (crv)
			CRV_G1_FWD:  v = 12'd2800;
			CRV_G1_TURN: v = 12'd2800;
			CRV_G2_FWD:  v = 12'd3170;
			default:     v = 12'd3129;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/stjl_horner.sv
// One cubic evaluation lane: Horner steps on a bit-serial shift-add
// multiplier, then clamp and truncation to a joystick code. Uses stjl_pkg.
module stjl_horner #(
	parameter int FRAC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stjl_pkg::hn_req_t req,
	output stjl_pkg::hn_rsp_t rsp
);
	import stjl_pkg::*;

	localparam int H_W = A_W + 2;        // upper half of the product register
	localparam int P_W = H_W + SPD_W;    // full product width

	hn_state_t state_q, state_d;

	logic                    ld, mul_en, add_en, clamp_en;
	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              k_q;
	logic                    done_q;
	crv_t                    crv_q;
	logic signed [A_W-1:0]   a_q;
	logic signed [H_W-1:0]   hi_q;
	logic [SPD_W-1:0]        lo_q;
	logic [SPD_W-1:0]        s_q;
	logic [SPD_W-1:0]        spd_q;
	logic [LVL_W-1:0]        level_q;

	logic                    last_bit;
	logic signed [H_W-1:0]   pp_mag, pp, hi_sum;
	logic signed [P_W-1:0]   prod, prod_sh;
	logic signed [A_W-1:0]   a_next;
	logic signed [A_W-1:0]   lo_fix, hi_fix;
	logic [LVL_W-1:0]        clamped;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			HN_IDLE:  if (req.start) state_d = HN_MUL;
			HN_MUL:   if (last_bit) state_d = HN_ADD;
			HN_ADD:   state_d = (k_q == 2'd3) ? HN_CLAMP : HN_MUL;
			HN_CLAMP: state_d = HN_IDLE;
			default:  state_d = HN_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ld       = 1'b0;
		mul_en   = 1'b0;
		add_en   = 1'b0;
		clamp_en = 1'b0;
		case (state_q)
			HN_IDLE:  ld = req.start;
			HN_MUL:   mul_en = 1'b1;
			HN_ADD:   add_en = 1'b1;
			HN_CLAMP: clamp_en = 1'b1;
			default:  ld = 1'b0;
		endcase
	end

	// serial partial product; the sign bit of the speed has negative weight
	assign last_bit = (cnt_q == CNT_W'(SPD_W - 1));
	assign pp_mag   = s_q[0] ? {{(H_W-A_W){a_q[A_W-1]}}, a_q} : '0;
	assign pp       = last_bit ? -pp_mag : pp_mag;
	assign hi_sum   = hi_q + pp;

	// floor(a * s / 2^FRAC_BITS) + next coefficient
	assign prod    = $signed({hi_q, lo_q});
	assign prod_sh = prod >>> FRAC_BITS;
	assign a_next  = prod_sh[A_W-1:0] + crv_coef(crv_q, k_q);

	// clamp to the curve limits, keep the integer part
	assign lo_fix = $signed({{(A_W-LVL_W-FIX_SH){1'b0}}, crv_lo(crv_q), {FIX_SH{1'b0}}});
	assign hi_fix = $signed({{(A_W-LVL_W-FIX_SH){1'b0}}, crv_hi(crv_q), {FIX_SH{1'b0}}});
	always_comb begin
		if (a_q > hi_fix) begin
			clamped = crv_hi(crv_q);
		end else if (a_q < lo_fix) begin
			clamped = crv_lo(crv_q);
		end else begin
			clamped = a_q[FIX_SH +: LVL_W];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HN_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= clamp_en;
			if (ld) begin
				cnt_q <= '0;
				k_q   <= 2'd1;
			end else if (mul_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (add_en) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ld) begin
			crv_q <= req.curve;
			a_q   <= crv_coef(req.curve, 2'd0);
			spd_q <= req.speed;
			s_q   <= req.speed;
			hi_q  <= '0;
			lo_q  <= '0;
		end else if (mul_en) begin
			hi_q <= hi_sum >>> 1;
			lo_q <= {hi_sum[0], lo_q[SPD_W-1:1]};
			s_q  <= {1'b0, s_q[SPD_W-1:1]};
		end else if (add_en) begin
			a_q  <= a_next;
			hi_q <= '0;
			lo_q <= '0;
			s_q  <= spd_q;
		end
		if (clamp_en) begin
			level_q <= clamped;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.level = level_q;

	// a new request only lands on an idle lane
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == HN_IDLE)
		else $error("horner lane restarted while busy");

	// an add step follows exactly a full serial multiply
	a_add_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == HN_ADD |-> $past(state_q) == HN_MUL && $past(last_bit))
		else $error("horner add step without full multiply");

	// finished code lies within the curve limits
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> level_q >= crv_lo(crv_q) && level_q <= crv_hi(crv_q))
		else $error("horner level outside curve limits");

endmodule

FILE: rtl/core/speed_to_joystick_level_unit.sv
// Top level of the speed to joystick level unit: command decode, change
// detection, threshold overrides, two Horner lanes and the result register.
// Uses stjl_pkg and stjl_horner.

// Each command item carries an operation (gear-one curve, gear-two curve or
// direct levels) and is turned into a turn code and a forward code. A
// command whose operand pair and speed-or-direct kind match the last
// command that was not dropped gives no result; the gear is not compared.
// Operation code 3 is dropped. A command that repeats the last one or is
// dropped leaves the sequencer idle. A direct command registers its codes
// at acceptance and a speed command waits for the lanes; the codes then
// wait in the pending state until the output register is free, and the next
// command is taken only once they have moved there. Both codes are evaluated
// in parallel lanes, each running three Horner steps of a bit-serial
// multiply and an add, then a clamp step. The result register lets the next
// command be taken while a result waits on the output.
module speed_to_joystick_level_unit #(
	parameter int LEVEL_BITS      = 12,
	parameter int SPEED_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [1:0]         operation,
	input  logic signed [15:0] forward_speed,
	input  logic signed [15:0] turn_speed,
	input  logic [11:0]        forward_direct,
	input  logic [11:0]        turn_direct,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [11:0]        turn_level,
	output logic [11:0]        forward_level
);
	import stjl_pkg::*;

	localparam int S = 1 << SPEED_FRAC_BITS;
	localparam logic [LVL_W-1:0] LVL_MASK =
		(LEVEL_BITS >= LVL_W) ? '1 : LVL_W'((1 << LEVEL_BITS) - 1);

	ctl_state_t state_q, state_d;

	logic               accept, fire, out_load;
	op_t                op;
	logic               direct, same;
	logic [SPD_W-1:0]   fop, top;
	logic signed [31:0] xs, ys;
	logic               fwd_ovr, trn_ovr;
	logic [LVL_W-1:0]   fwd_code, trn_code;
	logic [SPD_W-1:0]   trn_eval;

	logic [SPD_W-1:0]   last_fwd_q, last_trn_q;
	logic               last_dir_q, have_last_q;
	logic               fwd_ovr_q, trn_ovr_q;
	logic [LVL_W-1:0]   fwd_code_q, trn_code_q;
	logic [LVL_W-1:0]   res_fwd_q, res_trn_q;
	logic               res_valid_q;
	logic [LVL_W-1:0]   turn_level_q, forward_level_q;

	hn_req_t fwd_req, trn_req;
	hn_rsp_t fwd_rsp, trn_rsp;

	// command decode and change detection
	assign accept = cmd_valid && cmd_ready;
	assign op     = op_t'(operation);
	assign direct = (op == OP_DIRECT);
	assign fop    = direct ? {4'b0, forward_direct} : forward_speed;
	assign top    = direct ? {4'b0, turn_direct} : turn_speed;
	assign same   = have_last_q && (direct == last_dir_q) &&
		(fop == last_fwd_q) && (top == last_trn_q);
	assign fire   = accept && (op != OP_NONE) && !same;

	assign xs = $signed({{16{forward_speed[15]}}, forward_speed});
	assign ys = $signed({{16{turn_speed[15]}}, turn_speed});

	// threshold and zero-speed overrides
	always_comb begin
		fwd_ovr  = 1'b1;
		trn_ovr  = 1'b1;
		fwd_code = '0;
		trn_code = '0;
		trn_eval = turn_speed;
		if (op == OP_GEAR1) begin
			if (100 * xs > 33 * S) begin
				fwd_code = G1F_HI_CODE;
			end else if (10 * xs < -2 * S) begin
				fwd_code = G1F_LO_CODE;
			end else if (xs == 0) begin
				fwd_code = G1F_ZERO_CODE;
			end else begin
				fwd_ovr = 1'b0;
			end
			if (10 * ys < -17 * S) begin
				trn_code = G1T_LO_CODE;
			end else if (ys == 0) begin
				trn_code = G1T_ZERO_CODE;
			end else begin
				trn_ovr = 1'b0;
			end
			// large turn speeds are evaluated at four
			if (ys > 4 * S) begin
				trn_eval = SPD_W'(4 * S);
			end
		end else begin
			if (xs > S) begin
				fwd_code = G2F_HI_CODE;
			end else if (2 * xs < -S) begin
				fwd_code = G2F_LO_CODE;
			end else if (xs == 0) begin
				fwd_code = G2F_ZERO_CODE;
			end else begin
				fwd_ovr = 1'b0;
			end
			if (ys < -S) begin
				trn_code = G2T_LO_CODE;
			end else if (ys > S) begin
				trn_code = G2T_HI_CODE;
			end else if (ys == 0) begin
				trn_code = G2T_ZERO_CODE;
			end else begin
				trn_ovr = 1'b0;
			end
		end
	end

	// lane requests
	assign fwd_req.start = fire && !direct;
	assign fwd_req.curve = (op == OP_GEAR1) ? CRV_G1_FWD : CRV_G2_FWD;
	assign fwd_req.speed = forward_speed;
	assign trn_req.start = fire && !direct;
	assign trn_req.curve = (op == OP_GEAR1) ? CRV_G1_TURN : CRV_G2_TURN;
	assign trn_req.speed = trn_eval;

	stjl_horner #(.FRAC_BITS(SPEED_FRAC_BITS)) u_fwd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fwd_req),
		.rsp    (fwd_rsp)
	);

	stjl_horner #(.FRAC_BITS(SPEED_FRAC_BITS)) u_trn (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (trn_req),
		.rsp    (trn_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (fire) state_d = direct ? ST_PEND : ST_CALC;
			end
			ST_CALC: if (fwd_rsp.done) state_d = ST_PEND;
			ST_PEND: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: cmd_ready = 1'b1;
			ST_PEND: out_load = !res_valid_q || res_ready;
			default: cmd_ready = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_fwd_q  <= '0;
			last_trn_q  <= '0;
			last_dir_q  <= 1'b0;
			have_last_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				last_fwd_q  <= fop;
				last_trn_q  <= top;
				last_dir_q  <= direct;
				have_last_q <= 1'b1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (fire) begin
			fwd_ovr_q  <= fwd_ovr;
			trn_ovr_q  <= trn_ovr;
			fwd_code_q <= fwd_code;
			trn_code_q <= trn_code;
			if (direct) begin
				res_fwd_q <= forward_direct & LVL_MASK;
				res_trn_q <= turn_direct & LVL_MASK;
			end
		end
		if (state_q == ST_CALC && fwd_rsp.done) begin
			res_fwd_q <= (fwd_ovr_q ? fwd_code_q : fwd_rsp.level) & LVL_MASK;
			res_trn_q <= (trn_ovr_q ? trn_code_q : trn_rsp.level) & LVL_MASK;
		end
		if (out_load) begin
			turn_level_q    <= res_trn_q;
			forward_level_q <= res_fwd_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign turn_level    = turn_level_q;
	assign forward_level = forward_level_q;

	// both lanes run in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_rsp.done == trn_rsp.done)
		else $error("curve lanes out of step");

	// lane results only arrive while a speed item is at work
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_rsp.done |-> state_q == ST_CALC)
		else $error("lane result outside calculation");

	// a new result only comes out of the pending stage
	a_rise_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_PEND)
		else $error("result raised without pending item");

	// delivered codes fit the level width
	a_level_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((turn_level_q & ~LVL_MASK) == '0) &&
			((forward_level_q & ~LVL_MASK) == '0))
		else $error("result code exceeds level width");

endmodule

FILE: verif/stjl_level_checker.sv
`timescale 1ns / 100ps
// Checker for the speed to joystick level unit: watches both channels, predicts the
// levels of each accepted command that is not dropped or a repeat, compares each result
// with the oldest prediction. Depends on stjl_pkg for the operation and curve enums.
module stjl_level_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  logic [1:0]         operation,
	input  logic signed [15:0] forward_speed,
	input  logic signed [15:0] turn_speed,
	input  logic [11:0]        forward_direct,
	input  logic [11:0]        turn_direct,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic [11:0]        turn_level,
	input  logic [11:0]        forward_level,
	output int                 mismatches,
	output int                 levels_pending
);
	import stjl_pkg::*;

	localparam int     SPEED_FRAC = 12;
	localparam longint SPD_ONE    = longint'(1) << SPEED_FRAC;
	localparam int     REPORT_MAX = 10;

	// Q16 cubic coefficients, highest power first, in crv_t order
	localparam longint CUBIC_Q16 [4][4] = '{
		'{-931725312, -122912768, 370422579, 127710003},
		'{12021924, -1255539, -75202560, 132356506},
		'{1291059, -27996979, 104674099, 130659123},
		'{34360525, -10702029, -121818317, 125665280}
	};

	typedef struct packed {
		logic [11:0] turn;
		logic [11:0] fwd;
	} levels_t;

	levels_t     levels_due[$];
	logic [15:0] last_fwd_opnd;
	logic [15:0] last_turn_opnd;
	logic        last_direct;
	logic        have_last;
	int          fail_total;

	// Horner evaluation with floor shifts, clamped, integer part of Q16
	function automatic logic [11:0] cubic_level(crv_t crv, longint s, longint lo, longint hi);
		longint acc;
		acc = CUBIC_Q16[int'(crv)][0];
		for (int k = 1; k < 4; k++)
			acc = ((acc * s) >>> SPEED_FRAC) + CUBIC_Q16[int'(crv)][k];
		if (acc > hi * 65536)
			acc = hi * 65536;
		if (acc < lo * 65536)
			acc = lo * 65536;
		return acc[27:16];
	endfunction

	// levels of one command whose operands differ from the last one
	function automatic levels_t map_levels(op_t op, logic [15:0] f, logic [15:0] t);
		levels_t lv;
		longint  x;
		longint  y;
		x = $signed(f);
		y = $signed(t);
		if (op == OP_DIRECT) begin
			lv.fwd  = f[11:0];
			lv.turn = t[11:0];
		end else if (op == OP_GEAR1) begin
			if (100 * x > 33 * SPD_ONE)
				lv.fwd = 12'd2800;
			else if (10 * x < -2 * SPD_ONE)
				lv.fwd = 12'd850;
			else if (x == 0)
				lv.fwd = 12'd2028;
			else
				lv.fwd = cubic_level(CRV_G1_FWD, x, 850, 2800);
			if (10 * y < -17 * SPD_ONE)
				lv.turn = 12'd2800;
			else if (y == 0)
				lv.turn = 12'd2044;
			else begin
				// large turn speeds are evaluated at 4.0
				if (y > 4 * SPD_ONE)
					y = 4 * SPD_ONE;
				lv.turn = cubic_level(CRV_G1_TURN, y, 850, 2800);
			end
		end else begin
			if (x > SPD_ONE)
				lv.fwd = 12'd3170;
			else if (2 * x < -SPD_ONE)
				lv.fwd = 12'd1020;
			else if (x == 0)
				lv.fwd = 12'd2040;
			else
				lv.fwd = cubic_level(CRV_G2_FWD, x, 1020, 3170);
			if (y < -SPD_ONE)
				lv.turn = 12'd3129;
			else if (y > SPD_ONE)
				lv.turn = 12'd780;
			else if (y == 0)
				lv.turn = 12'd2000;
			else
				lv.turn = cubic_level(CRV_G2_TURN, y, 780, 3129);
		end
		return lv;
	endfunction

	// channel monitor: results are checked before the command of the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		levels_t     want;
		levels_t     got;
		logic        is_direct;
		logic [15:0] f_opnd;
		logic [15:0] t_opnd;
		if (!arst_n) begin
			levels_due.delete();
			last_fwd_opnd  = '0;
			last_turn_opnd = '0;
			last_direct    = 1'b0;
			have_last      = 1'b0;
			fail_total     = 0;
			mismatches     <= 0;
			levels_pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				got.turn = turn_level;
				got.fwd  = forward_level;
				if (levels_due.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_MAX)
						$display("unexpected result: turn %0d forward %0d", got.turn, got.fwd);
				end else begin
					want = levels_due.pop_front();
					if (got != want) begin
						fail_total++;
						if (fail_total <= REPORT_MAX)
							$display("level mismatch: turn exp %0d got %0d, forward exp %0d got %0d",
								want.turn, got.turn, want.fwd, got.fwd);
					end
				end
			end

			// unused operation code is dropped
			if (cmd_valid && cmd_ready && op_t'(operation) != OP_NONE) begin
				is_direct = (op_t'(operation) == OP_DIRECT);
				f_opnd    = is_direct ? {4'b0, forward_direct} : forward_speed;
				t_opnd    = is_direct ? {4'b0, turn_direct} : turn_speed;
				// gear is not part of the change detection
				if (!(have_last && is_direct == last_direct &&
					f_opnd == last_fwd_opnd && t_opnd == last_turn_opnd)) begin
					have_last      = 1'b1;
					last_direct    = is_direct;
					last_fwd_opnd  = f_opnd;
					last_turn_opnd = t_opnd;
					levels_due.push_back(map_levels(op_t'(operation), f_opnd, t_opnd));
				end
			end
			mismatches     <= fail_total;
			levels_pending <= levels_due.size();
		end
	end

endmodule

FILE: verif/speed_to_joystick_level_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the speed to joystick level unit: drives directed and random
// drive commands under several idle patterns and gives the verdict.
// Depends on stjl_pkg, speed_to_joystick_level_unit and stjl_level_checker.
module speed_to_joystick_level_unit_test;
	import stjl_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 11;
	localparam int RANDOM_PER_PHASE = 270;
	localparam int HOLD_OFF_CYCLES  = 500;
	localparam int DRAIN_CYCLES     = 200;
	localparam int MAX_GAP          = 40;
	localparam int CYCLE_LIMIT      = 1000000;

	// idle percentages per phase: none, sender, receiver, both
	localparam int PHASE_TX [4] = '{0, 64, 0, 27};
	localparam int PHASE_RX [4] = '{0, 0, 64, 27};

	// speeds at and around every threshold of the curves
	localparam int SPEED_MARKS [19] = '{
		1351, 1352, -819, -820, -6963, -6964, 16384, 16385, 4096, 4097,
		-4096, -4097, -2048, -2049, 0, 1, -1, 32767, -32768
	};

	typedef struct {
		op_t                op;
		logic signed [15:0] fwd;
		logic signed [15:0] turn;
		logic [11:0]        fwd_dir;
		logic [11:0]        turn_dir;
	} drive_cmd_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               cmd_valid      = 1'b0;
	logic               cmd_ready;
	logic [1:0]         operation      = OP_GEAR1;
	logic signed [15:0] forward_speed  = '0;
	logic signed [15:0] turn_speed     = '0;
	logic [11:0]        forward_direct = '0;
	logic [11:0]        turn_direct    = '0;
	logic               res_valid;
	logic               res_ready      = 1'b0;
	logic [11:0]        turn_level;
	logic [11:0]        forward_level;

	int          mismatches;
	int          levels_pending;
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	bit          hold_armed   = 1'b0;
	int unsigned cycle_count  = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	speed_to_joystick_level_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.operation      (operation),
		.forward_speed  (forward_speed),
		.turn_speed     (turn_speed),
		.forward_direct (forward_direct),
		.turn_direct    (turn_direct),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.turn_level     (turn_level),
		.forward_level  (forward_level)
	);

	stjl_level_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.operation      (operation),
		.forward_speed  (forward_speed),
		.turn_speed     (turn_speed),
		.forward_direct (forward_direct),
		.turn_direct    (turn_direct),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.turn_level     (turn_level),
		.forward_level  (forward_level),
		.mismatches     (mismatches),
		.levels_pending (levels_pending)
	);

	// run time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: one long hold-off once armed, random stalls otherwise
	initial begin : rx_side
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			res_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic drive_cmd_t cmd_of(op_t op, int f, int t, int fd, int td);
		drive_cmd_t c;
		c.op       = op;
		c.fwd      = f[15:0];
		c.turn     = t[15:0];
		c.fwd_dir  = fd[11:0];
		c.turn_dir = td[11:0];
		return c;
	endfunction

	// speeds weighted toward the curved regions and the thresholds
	function automatic logic [15:0] pick_speed();
		int v;
		case ($urandom_range(9))
			0, 1:    v = $urandom;
			2:       v = 0;
			3:       v = SPEED_MARKS[$urandom_range(18)];
			4, 5:    v = int'($urandom_range(3000)) - 1500;
			6, 7:    v = int'($urandom_range(16384)) - 8192;
			8:       v = int'($urandom_range(3500)) - 2100;
			default: v = SPEED_MARKS[$urandom_range(18)] + int'($urandom_range(4)) - 2;
		endcase
		return v[15:0];
	endfunction

	function automatic logic [11:0] pick_level();
		case ($urandom_range(5))
			0:       return 12'h000;
			1:       return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	// fresh commands, exact repeats, gear swaps and the odd dropped code
	function automatic drive_cmd_t next_cmd(drive_cmd_t prev);
		drive_cmd_t  c;
		int unsigned r;
		r          = $urandom_range(99);
		c.op       = op_t'($urandom_range(2));
		c.fwd      = pick_speed();
		c.turn     = pick_speed();
		c.fwd_dir  = pick_level();
		c.turn_dir = pick_level();
		if (r < 4) begin
			c.op = OP_NONE;
		end else if (r < 16) begin
			// same operands again; the fields the operation ignores still change
			c.op = prev.op;
			if (prev.op == OP_DIRECT) begin
				c.fwd_dir  = prev.fwd_dir;
				c.turn_dir = prev.turn_dir;
			end else begin
				c.fwd  = prev.fwd;
				c.turn = prev.turn;
			end
		end else if (r < 22 && prev.op != OP_DIRECT) begin
			c.op   = (prev.op == OP_GEAR1) ? OP_GEAR2 : OP_GEAR1;
			c.fwd  = prev.fwd;
			c.turn = prev.turn;
		end
		return c;
	endfunction

	// offer one item after a random gap and wait until it is taken
	task automatic issue_cmd(input drive_cmd_t c);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid      <= 1'b1;
		operation      <= c.op;
		forward_speed  <= c.fwd;
		turn_speed     <= c.turn;
		forward_direct <= c.fwd_dir;
		turn_direct    <= c.turn_dir;
		do @(posedge clk); while (!cmd_ready);
	endtask

	initial begin : stimulus
		drive_cmd_t c;
		int         counted;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first command, repeats, gear swap, kind change, thresholds, extremes
		issue_cmd(cmd_of(OP_GEAR1, 0, 0, 123, 456));
		issue_cmd(cmd_of(OP_GEAR1, 0, 0, 789, 12));
		issue_cmd(cmd_of(OP_GEAR2, 0, 0, 5, 6));
		issue_cmd(cmd_of(OP_DIRECT, 1, -1, 0, 0));
		issue_cmd(cmd_of(OP_DIRECT, 0, 0, 4095, 4095));
		issue_cmd(cmd_of(OP_DIRECT, 77, 88, 4095, 4095));
		issue_cmd(cmd_of(OP_NONE, -32768, 32767, 4095, 0));
		issue_cmd(cmd_of(OP_GEAR1, 1352, -6964, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, 1351, -6963, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, -820, 16385, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, -819, 16384, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, 32767, 32767, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, -32768, -32768, 0, 0));
		issue_cmd(cmd_of(OP_GEAR2, 4097, -4097, 0, 0));
		issue_cmd(cmd_of(OP_GEAR2, 4096, 4097, 0, 0));
		issue_cmd(cmd_of(OP_GEAR2, -2049, 4096, 0, 0));
		issue_cmd(cmd_of(OP_GEAR2, -2048, -4096, 0, 0));
		issue_cmd(cmd_of(OP_GEAR2, -32768, 32767, 0, 0));
		issue_cmd(cmd_of(OP_GEAR2, 1, -1, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, -1, 1, 0, 0));
		issue_cmd(cmd_of(OP_GEAR1, 5, 7, 0, 0));
		issue_cmd(cmd_of(OP_DIRECT, 5, 7, 5, 7));
		// the last directed command also seeds the random sequence
		c = cmd_of(OP_DIRECT, 0, 0, 12'hAAA, 12'h555);
		issue_cmd(c);

		// random phases; the long receiver hold-off falls in the first
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = PHASE_TX[p];
			rx_stall_pct = PHASE_RX[p];
			if (p == 0)
				hold_armed = 1'b1;
			counted = 0;
			while (counted < RANDOM_PER_PHASE) begin
				c = next_cmd(c);
				issue_cmd(c);
				if (c.op != OP_NONE)
					counted++;
			end
		end
		cmd_valid <= 1'b0;

		// drain, then allow for any late or stray result
		do @(posedge clk); while (levels_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && levels_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
